@@ src/rrfa_pkg.sv @@
package rrfa_pkg;

    localparam int MAX_SEATS         = 8;
    localparam int SEAT_W            = $clog2(MAX_SEATS);
    localparam int CNT_W             = $clog2(MAX_SEATS + 1);
    localparam int NEIGHBOURS_NEEDED = 2;
    localparam int KIND_W            = 2;
    localparam int MIN_SEATS         = 2;

    typedef logic [SEAT_W-1:0]    seat_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [MAX_SEATS-1:0] seat_mask_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST   = 2'd0,
        KIND_RELEASE   = 2'd1,
        KIND_TERMINATE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DENY,
        ST_DONE
    } state_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        count_t     seats;
        seat_mask_t busy;
        seat_mask_t present;
        logic       append;
        seat_t      append_seat;
        logic       scan_en;
        logic       pop_en;
        logic       commit;
    } cell_ctl_t;

    // Link passed from one cell to the next one toward the tail
    typedef struct packed {
        logic occupied;
        logic found;
    } cell_link_t;

    // Resource on the right-hand side of a seat
    function automatic seat_t ring_next(input seat_t s, input count_t n);
        count_t nx;
        nx = count_t'(s) + count_t'(1);
        return (nx >= n) ? seat_t'(0) : nx[SEAT_W-1:0];
    endfunction

    // Seat values that count as ring neighbors of s
    function automatic seat_mask_t adj_mask(input seat_t s, input count_t n);
        seat_mask_t m;
        count_t     nm1;
        m   = '0;
        nm1 = n - count_t'(1);
        if (s != seat_t'(MAX_SEATS - 1))
            m[seat_t'(s + seat_t'(1))] = 1'b1;
        if (s != seat_t'(0))
            m[seat_t'(s - seat_t'(1))] = 1'b1;
        if (s == seat_t'(0))
            m[nm1[SEAT_W-1:0]] = 1'b1;
        if (count_t'(s) == nm1)
            m[0] = 1'b1;
        return m;
    endfunction

    function automatic count_t clamp_seats(input count_t v);
        if (v < count_t'(MIN_SEATS))
            return count_t'(MIN_SEATS);
        else if (v > count_t'(MAX_SEATS))
            return count_t'(MAX_SEATS);
        else
            return v;
    endfunction

endpackage

@@ src/rrfa_ifs.sv @@
interface rrfa_in_if import rrfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SEAT_W-1:0]   seat;

    modport source (output valid, kind, seat, input ready);
    modport sink   (input valid, kind, seat, output ready);
endinterface

interface rrfa_out_if import rrfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SEAT_W-1:0]   grant_seat;
    logic                granted;
    logic                last;

    modport source (output valid, grant_seat, granted, last, input ready);
    modport sink   (input valid, grant_seat, granted, last, output ready);
endinterface

@@ src/rrfa_cell.sv @@
module rrfa_cell
    import rrfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head,
    input  cell_ctl_t  ctl,
    input  cell_link_t link_in,
    input  logic       nxt_valid,
    input  seat_t      nxt_seat,
    output cell_link_t link_out,
    output logic       valid,
    output seat_t      seat,
    output logic       sel
);

    logic  valid_reg;
    logic  valid_next;
    seat_t seat_reg;
    seat_t seat_next;
    logic  eligible;
    logic  take;
    logic  load;
    logic  res_free;
    logic  near_ok;

    always_comb
    begin
        res_free = !ctl.busy[seat_reg] && !ctl.busy[ring_next(seat_reg, ctl.seats)];
        near_ok  = head ||
                   ($countones(adj_mask(seat_reg, ctl.seats) & ctl.present)
                    == NEIGHBOURS_NEEDED);
        eligible = (count_t'(seat_reg) < ctl.seats) && res_free && near_ok;
    end

    assign sel  = valid_reg && !link_in.found &&
                  ((ctl.scan_en && eligible) || (ctl.pop_en && head));
    // Once an entry ahead is picked, everything behind moves up one place
    assign take = ctl.commit && (sel || link_in.found);
    assign load = ctl.append && !valid_reg && link_in.occupied;

    always_comb
    begin
        valid_next = valid_reg;
        seat_next  = seat_reg;
        if (take)
        begin
            valid_next = nxt_valid;
            seat_next  = nxt_seat;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            seat_next  = ctl.append_seat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        seat_reg <= seat_next;
    end

    assign link_out.occupied = valid_reg;
    assign link_out.found    = link_in.found || sel;
    assign valid             = valid_reg;
    assign seat              = seat_reg;

endmodule

@@ src/ring_resource_fair_arbiter.sv @@
// Request, release or unknown word: the queue is rescanned, then the held result is flushed
// before the next accept (at most 4 grants on a ring of 8); once stopped, there is no rescan.
// Terminate: each waiter is denied; the queue drains one entry a cycle unless the sink stalls.
// The rescan picks one grant per cycle from the chain of queue cells unless the sink stalls.
// Results leave through a one-word hold stage and an output register.
// Reset (rst_n low, asynchronous) empties the queue, frees all resources, clears stop.
module ring_resource_fair_arbiter
    import rrfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    rrfa_in_if.sink             in_ch,
    rrfa_out_if.source          out_ch,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_data
);

    state_t     state_reg;
    state_t     state_next;
    count_t     seats_reg;
    seat_mask_t busy_reg;
    seat_mask_t busy_next;
    logic       stopped_reg;
    logic       stopped_next;

    logic       pend_valid_reg;
    logic       pend_valid_next;
    seat_t      pend_seat_reg;
    seat_t      pend_seat_next;
    logic       pend_granted_reg;
    logic       pend_granted_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    seat_t      out_seat_reg;
    seat_t      out_seat_next;
    logic       out_granted_reg;
    logic       out_granted_next;
    logic       out_last_reg;
    logic       out_last_next;

    cell_ctl_t  ctl;
    cell_link_t link [MAX_SEATS+1];
    logic       q_valid [MAX_SEATS];
    seat_t      q_seat  [MAX_SEATS];
    logic [MAX_SEATS-1:0] q_valid_vec;
    logic [MAX_SEATS-1:0] q_sel;
    seat_mask_t present;
    seat_t      sel_seat;
    logic       hit_any;
    logic       out_free;
    logic       can;
    logic       emit_en;
    seat_t      emit_seat;
    logic       emit_granted;
    logic       append;
    seat_t      in_seat;
    logic       seat_ok;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign can      = !pend_valid_reg || out_free;
    assign in_seat  = in_ch.seat;
    assign seat_ok  = count_t'(in_seat) < seats_reg;

    always_comb
    begin
        present  = '0;
        sel_seat = '0;
        for (int i = 0; i < MAX_SEATS; i++)
        begin
            q_valid_vec[i] = q_valid[i];
            if (q_valid[i])
                present[q_seat[i]] = 1'b1;
            if (q_sel[i])
                sel_seat = sel_seat | q_seat[i];
        end
        hit_any = |q_sel;
    end

    always_comb
    begin
        ctl.seats       = seats_reg;
        ctl.busy        = busy_reg;
        ctl.present     = present;
        ctl.append      = append;
        ctl.append_seat = in_seat;
        ctl.scan_en     = (state_reg == ST_SCAN);
        ctl.pop_en      = (state_reg == ST_DENY);
        ctl.commit      = can;
    end

    assign link[0] = '{occupied: 1'b1, found: 1'b0};

    for (genvar g = 0; g < MAX_SEATS; g++)
    begin : g_cell
        logic  nv;
        seat_t ns;
        if (g == MAX_SEATS - 1)
        begin : g_tail
            assign nv = 1'b0;
            assign ns = '0;
        end
        else
        begin : g_mid
            assign nv = q_valid[g+1];
            assign ns = q_seat[g+1];
        end

        rrfa_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .head      (g == 0),
            .ctl       (ctl),
            .link_in   (link[g]),
            .nxt_valid (nv),
            .nxt_seat  (ns),
            .link_out  (link[g+1]),
            .valid     (q_valid[g]),
            .seat      (q_seat[g]),
            .sel       (q_sel[g])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        busy_next         = busy_reg;
        stopped_next      = stopped_reg;
        pend_valid_next   = pend_valid_reg;
        pend_seat_next    = pend_seat_reg;
        pend_granted_next = pend_granted_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_seat_next     = out_seat_reg;
        out_granted_next  = out_granted_reg;
        out_last_next     = out_last_reg;
        emit_en           = 1'b0;
        emit_seat         = sel_seat;
        emit_granted      = 1'b0;
        append            = 1'b0;
        in_ch.ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = stopped_reg ? ST_DONE : ST_SCAN;
                    case (kind_t'(in_ch.kind))
                        KIND_REQUEST:
                        begin
                            if (seat_ok && !present[in_seat])
                            begin
                                if (stopped_reg)
                                begin
                                    emit_en      = 1'b1;
                                    emit_seat    = in_seat;
                                    emit_granted = 1'b0;
                                end
                                else
                                    append = 1'b1;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            if (seat_ok)
                            begin
                                busy_next[in_seat]                       = 1'b0;
                                busy_next[ring_next(in_seat, seats_reg)] = 1'b0;
                            end
                        end
                        KIND_TERMINATE:
                        begin
                            if (!stopped_reg)
                            begin
                                stopped_next = 1'b1;
                                state_next   = ST_DENY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!hit_any)
                    state_next = ST_DONE;
                else if (can)
                begin
                    emit_en                                   = 1'b1;
                    emit_granted                              = 1'b1;
                    busy_next[sel_seat]                       = 1'b1;
                    busy_next[ring_next(sel_seat, seats_reg)] = 1'b1;
                end
            end
            ST_DENY:
            begin
                if (!hit_any)
                    state_next = ST_DONE;
                else if (can)
                begin
                    emit_en      = 1'b1;
                    emit_granted = 1'b0;
                end
            end
            ST_DONE:
            begin
                // Flush the held word, now known to be the final one
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_seat_next    = pend_seat_reg;
                    out_granted_next = pend_granted_reg;
                    out_last_next    = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // Hold each new word until the next one shows whether it was the last
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_seat_next    = pend_seat_reg;
                out_granted_next = pend_granted_reg;
                out_last_next    = 1'b0;
            end
            pend_valid_next   = 1'b1;
            pend_seat_next    = emit_seat;
            pend_granted_next = emit_granted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seats_reg      <= count_t'(MAX_SEATS);
            busy_reg       <= '0;
            stopped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            stopped_reg    <= stopped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                seats_reg <= clamp_seats(cfg_data);
        end
    end

    always_ff @(posedge clk)
    begin
        pend_seat_reg    <= pend_seat_next;
        pend_granted_reg <= pend_granted_next;
        out_seat_reg     <= out_seat_next;
        out_granted_reg  <= out_granted_next;
        out_last_reg     <= out_last_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.grant_seat = out_seat_reg;
    assign out_ch.granted    = out_granted_reg;
    assign out_ch.last       = out_last_reg;

    a_queue_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid_vec & (q_valid_vec + 1'b1)) == '0)
        else $error("queue cells not packed toward the head");

    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(q_sel))
        else $error("more than one queue cell picked");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held word left over at idle");

    a_grant_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && hit_any && can) |=> busy_reg[$past(sel_seat)])
        else $error("granted seat did not take its resource");

    a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg && state_reg == ST_IDLE) |-> (q_valid_vec == '0))
        else $error("waiters left after terminate");

endmodule

@@ bench/tb_ring_resource_fair_arbiter.sv @@
module tb_ring_resource_fair_arbiter;
    timeunit 1ns;
    timeprecision 1ps;

    import rrfa_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 30;
    localparam int PHASE_WORDS   = 14;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_QUIET,
        ROW_ONE,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         how;
        logic [KIND_W-1:0] kind;
        seat_t             seat;
        count_t            cfg_val;
        seat_t             t_seat;
        logic              t_granted;
    } row_t;

    typedef struct packed {
        seat_t seat;
        logic  granted;
        logic  last;
    } decision_t;

    localparam row_t OPENING_ROWS [28] = '{
        '{ROW_ONE,   KIND_REQUEST, 3'd0, 4'd0,  3'd0, 1'b1},
        '{ROW_QUIET, KIND_REQUEST, 3'd1, 4'd0,  3'd0, 1'b0},
        '{ROW_QUIET, KIND_REQUEST, 3'd1, 4'd0,  3'd0, 1'b0},
        '{ROW_ONE,   KIND_RELEASE, 3'd0, 4'd0,  3'd1, 1'b1},
        '{ROW_ONE,   KIND_REQUEST, 3'd7, 4'd0,  3'd7, 1'b1},
        '{ROW_QUIET, KIND_UNKNOWN, 3'd5, 4'd0,  3'd0, 1'b0},
        '{ROW_ONE,   KIND_REQUEST, 3'd3, 4'd0,  3'd3, 1'b1},
        '{ROW_QUIET, KIND_REQUEST, 3'd6, 4'd0,  3'd0, 1'b0},
        '{ROW_QUIET, KIND_REQUEST, 3'd4, 4'd0,  3'd0, 1'b0},
        // seat 5 sits behind both of its neighbors and still wins
        '{ROW_ONE,   KIND_REQUEST, 3'd5, 4'd0,  3'd5, 1'b1},
        '{ROW_MODEL, KIND_RELEASE, 3'd7, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_RELEASE, 3'd5, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_RELEASE, 3'd3, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_RELEASE, 3'd2, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_RELEASE, 3'd6, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_RELEASE, 3'd4, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_RELEASE, 3'd1, 4'd0,  3'd0, 1'b0},
        // below the minimum: ring of two
        '{ROW_CFG,   KIND_REQUEST, 3'd0, 4'd1,  3'd0, 1'b0},
        '{ROW_ONE,   KIND_REQUEST, 3'd0, 4'd0,  3'd0, 1'b1},
        '{ROW_QUIET, KIND_REQUEST, 3'd1, 4'd0,  3'd0, 1'b0},
        '{ROW_QUIET, KIND_REQUEST, 3'd7, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_RELEASE, 3'd0, 4'd0,  3'd0, 1'b0},
        '{ROW_QUIET, KIND_RELEASE, 3'd6, 4'd0,  3'd0, 1'b0},
        '{ROW_CFG,   KIND_REQUEST, 3'd0, 4'd15, 3'd0, 1'b0},
        '{ROW_QUIET, KIND_REQUEST, 3'd7, 4'd0,  3'd0, 1'b0},
        // shrink the ring under the queued seat 7
        '{ROW_CFG,   KIND_REQUEST, 3'd0, 4'd5,  3'd0, 1'b0},
        '{ROW_QUIET, KIND_RELEASE, 3'd0, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_REQUEST, 3'd4, 4'd0,  3'd0, 1'b0}
    };

    localparam row_t CLOSING_ROWS [8] = '{
        '{ROW_CFG,   KIND_REQUEST,   3'd0, 4'd15, 3'd0, 1'b0},
        '{ROW_MODEL, KIND_REQUEST,   3'd2, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_REQUEST,   3'd5, 4'd0,  3'd0, 1'b0},
        '{ROW_MODEL, KIND_TERMINATE, 3'd0, 4'd0,  3'd0, 1'b0},
        '{ROW_QUIET, KIND_TERMINATE, 3'd7, 4'd0,  3'd0, 1'b0},
        '{ROW_ONE,   KIND_REQUEST,   3'd0, 4'd0,  3'd0, 1'b0},
        '{ROW_ONE,   KIND_REQUEST,   3'd7, 4'd0,  3'd7, 1'b0},
        '{ROW_QUIET, KIND_RELEASE,   3'd3, 4'd0,  3'd0, 1'b0}
    };

    localparam count_t PHASE_SIZES [7] = '{4'd8, 4'd3, 4'd0, 4'd6, 4'd2, 4'd4, 4'd8};

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    count_t cfg_data;
    bit     idling = 1'b1;
    int     mismatches = 0;

    // shadow of the arbiter
    int         ring_n = MAX_SEATS;
    seat_mask_t busy = '0;
    seat_mask_t holding = '0;
    bit         stopped = 1'b0;
    seat_t      waiters[$];
    decision_t  step_out[$];
    decision_t  decisions_due[$];

    rrfa_in_if  in_ch ();
    rrfa_out_if out_ch ();

    ring_resource_fair_arbiter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic decision_t make_decision(seat_t who, logic granted, logic last);
        decision_t d;
        d.seat    = who;
        d.granted = granted;
        d.last    = last;
        return d;
    endfunction

    function automatic void predict_decisions(logic [KIND_W-1:0] kind, seat_t who);
        int nxt;
        int near;
        int s;
        bit again;
        bit listed;
        step_out.delete();
        nxt = (int'(who) + 1 >= ring_n) ? 0 : int'(who) + 1;
        if (kind == KIND_REQUEST)
        begin
            listed = 1'b0;
            foreach (waiters[i])
                if (waiters[i] == who)
                    listed = 1'b1;
            if (who < ring_n && !listed)
            begin
                if (stopped)
                    step_out = {step_out, make_decision(who, 1'b0, 1'b0)};
                else if (waiters.size() < MAX_SEATS)
                    waiters = {waiters, who};
            end
        end
        else if (kind == KIND_RELEASE)
        begin
            if (who < ring_n)
            begin
                busy[who]    = 1'b0;
                busy[nxt]    = 1'b0;
                holding[who] = 1'b0;
            end
        end
        else if (kind == KIND_TERMINATE)
        begin
            if (!stopped)
            begin
                stopped = 1'b1;
                foreach (waiters[i])
                    step_out = {step_out, make_decision(waiters[i], 1'b0, 1'b0)};
                waiters.delete();
            end
        end
        // one grant per pass; restart from the head after every grant
        again = !stopped;
        while (again)
        begin
            again = 1'b0;
            for (int i = 0; i < waiters.size(); i++)
            begin
                s = waiters[i];
                if (s >= ring_n)
                    continue;
                nxt = (s + 1 >= ring_n) ? 0 : s + 1;
                if (busy[s] || busy[nxt])
                    continue;
                if (i != 0)
                begin
                    near = 0;
                    foreach (waiters[j])
                        if (waiters[j] == s + 1 || s == waiters[j] + 1 ||
                            (waiters[j] == 0 && s == ring_n - 1) ||
                            (s == 0 && waiters[j] == ring_n - 1))
                            near++;
                    if (near != NEIGHBOURS_NEEDED)
                        continue;
                end
                waiters.delete(i);
                busy[s]    = 1'b1;
                busy[nxt]  = 1'b1;
                holding[s] = 1'b1;
                step_out = {step_out, make_decision(seat_t'(s), 1'b1, 1'b0)};
                again = 1'b1;
                break;
            end
        end
        if (step_out.size() != 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    // drive at the falling edge, take the word at the rising edge it is accepted
    task automatic send_word(logic [KIND_W-1:0] kind, seat_t who, row_kind_t how,
                             seat_t t_seat, logic t_granted);
        if (idling && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 19)) @(negedge clk);
        in_ch.kind  = kind;
        in_ch.seat  = who;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_decisions(kind, who);
        if (how == ROW_MODEL)
        begin
            foreach (step_out[i])
                decisions_due = {decisions_due, step_out[i]};
        end
        else if (how == ROW_ONE)
        begin
            decisions_due = {decisions_due, make_decision(t_seat, t_granted, 1'b1)};
        end
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // only while idle: every result in, then let a silent rescan finish
    task automatic set_ring_size(count_t value);
        while (decisions_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data = value;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
        if (value < MIN_SEATS)
            ring_n = MIN_SEATS;
        else if (value > MAX_SEATS)
            ring_n = MAX_SEATS;
        else
            ring_n = value;
    endtask

    task automatic walk_row(row_t row);
        if (row.how == ROW_CFG)
            set_ring_size(row.cfg_val);
        else
            send_word(row.kind, row.seat, row.how, row.t_seat, row.t_granted);
    endtask

    task automatic random_phase(count_t size_val, int words);
        int               done;
        int               pick;
        logic [KIND_W-1:0] kind;
        seat_t            who;
        seat_t            owners[$];
        set_ring_size(size_val);
        done = 0;
        while (done < words)
        begin
            pick = $urandom_range(99);
            owners.delete();
            for (int s = 0; s < ring_n; s++)
                if (holding[s])
                    owners = {owners, seat_t'(s)};
            if (pick < 50)
            begin
                kind = KIND_REQUEST;
                if (pick < 46)
                    who = seat_t'($urandom_range(ring_n - 1));
                else
                    who = seat_t'($urandom_range(MAX_SEATS - 1));
            end
            else if (pick < 85 && owners.size() != 0)
            begin
                kind = KIND_RELEASE;
                who  = owners[$urandom_range(owners.size() - 1)];
            end
            else if (pick < 93)
            begin
                kind = KIND_RELEASE;
                who  = seat_t'($urandom_range(MAX_SEATS - 1));
            end
            else
            begin
                kind = KIND_UNKNOWN;
                who  = seat_t'($urandom_range(MAX_SEATS - 1));
            end
            done++;
            send_word(kind, who, ROW_MODEL, '0, 1'b0);
        end
    endtask

    // receiver: stall in random bursts while idling is on
    initial
    begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && idling && $urandom_range(5) == 0)
                hold = $urandom_range(1, 19);
            if (hold > 0)
            begin
                out_ch.ready = 1'b0;
                hold--;
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (decisions_due.size() == 0)
            begin
                report_mismatch("result with nothing pending, grant_seat",
                                int'(out_ch.grant_seat), -1);
            end
            else
            begin
                want = decisions_due.pop_front();
                if (out_ch.grant_seat !== want.seat)
                    report_mismatch("grant_seat", int'(out_ch.grant_seat), int'(want.seat));
                if (out_ch.granted !== want.granted)
                    report_mismatch("granted", int'(out_ch.granted), int'(want.granted));
                if (out_ch.last !== want.last)
                    report_mismatch("last", int'(out_ch.last), int'(want.last));
            end
        end
    end

    // watchdog: too long without any word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.kind  = KIND_REQUEST;
        in_ch.seat  = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (OPENING_ROWS[r])
            walk_row(OPENING_ROWS[r]);

        foreach (PHASE_SIZES[p])
        begin
            // no idling on every third phase and from the last phase on
            idling = (p % 3 != 2) && (p != $size(PHASE_SIZES) - 1);
            random_phase(PHASE_SIZES[p], PHASE_WORDS);
        end

        foreach (CLOSING_ROWS[r])
            walk_row(CLOSING_ROWS[r]);

        while (decisions_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
